### rtl/core/assert_macros.svh
// Assertion helpers used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/thadc_pkg.sv
package thadc_pkg;

  localparam int ADC_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int START_W   = 11;
  localparam int STEP_W    = 7;
  localparam int NUM_W     = 23;  // step * reading difference + half span
  localparam int CNT_W     = 5;
  localparam int CURVE_LEN = 106;

  // Calibration curve, ADC sum per table step, falling with temperature.
  localparam logic [ADC_W-1:0] CURVE [CURVE_LEN] = '{
    16'd3696, 16'd3675, 16'd3653, 16'd3630, 16'd3607, 16'd3582, 16'd3557, 16'd3531,
    16'd3504, 16'd3476, 16'd3448, 16'd3418, 16'd3388, 16'd3356, 16'd3324, 16'd3291,
    16'd3258, 16'd3223, 16'd3188, 16'd3152, 16'd3115, 16'd3078, 16'd3040, 16'd3001,
    16'd2961, 16'd2921, 16'd2881, 16'd2839, 16'd2797, 16'd2755, 16'd2713, 16'd2669,
    16'd2626, 16'd2582, 16'd2538, 16'd2494, 16'd2449, 16'd2404, 16'd2359, 16'd2313,
    16'd2268, 16'd2223, 16'd2177, 16'd2132, 16'd2087, 16'd2043, 16'd1999, 16'd1955,
    16'd1912, 16'd1869, 16'd1826, 16'd1784, 16'd1742, 16'd1701, 16'd1660, 16'd1620,
    16'd1580, 16'd1540, 16'd1502, 16'd1464, 16'd1426, 16'd1389, 16'd1353, 16'd1318,
    16'd1283, 16'd1249, 16'd1215, 16'd1183, 16'd1150, 16'd1119, 16'd1089, 16'd1058,
    16'd1029, 16'd1001, 16'd973,  16'd945,  16'd919,  16'd893,  16'd868,  16'd843,
    16'd819,  16'd796,  16'd773,  16'd751,  16'd730,  16'd709,  16'd689,  16'd669,
    16'd650,  16'd632,  16'd614,  16'd597,  16'd580,  16'd563,  16'd547,  16'd532,
    16'd516,  16'd502,  16'd487,  16'd473,  16'd460,  16'd447,  16'd434,  16'd422,
    16'd410,  16'd398
  };

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_STEP  = 2'd1,
    REG_UNDER = 2'd2,
    REG_OVER  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    RANGE_IN    = 2'd0,
    RANGE_UNDER = 2'd1,
    RANGE_OVER  = 2'd2
  } range_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_FIRST,
    ST_SEARCH,
    ST_LOW,
    ST_HIGH,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### rtl/core/thermistor_adc_to_temperature.sv
// Thermistor ADC sum to temperature converter.
// Input stream: s_axis_tdata_i carries one 16-bit summed ADC reading per transfer.
// Output stream: m_axis_tdata_o carries the temperature in tenths of a degree,
// m_axis_tuser_o the range status (0 in table, 1 clamped at start, 2 clamped at end).
// APB port: registers start_temperature (0x0), step_size (0x4), under_value (0x8)
// and over_value (0xC); write them only while no reading is in flight.
// One reading is worked at a time. A reading outside a table end goes from the
// end check that finds it straight to the output register; one equal to a table
// end passes the multiply first. Any other reading takes two end checks, one ROM
// read per binary search step (6 or 7 at 106 entries), the low and high entry
// lookups, the multiply, the bit-serial divider and the output load; a reading
// that lands on an entry skips the high lookup and the divider. The divider sets
// the rate; the next transfer can come at the edge after the output register loads.
// The result waits in an output register; the next reading is taken while it
// waits, and a finished result holds its last state until the register frees.
// Reset clears the stream state and loads the register defaults; the ROM is a
// constant table and needs no clearing.
`include "assert_macros.svh"

module thermistor_adc_to_temperature
  import thadc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 106
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ADC_W-1:0]  s_axis_tdata_i,   // [15:0] adc_sum
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TEMP_W-1:0] m_axis_tdata_o,   // [15:0] temperature
  output logic [1:0]        m_axis_tuser_o,   // [1:0] range_status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW     = $clog2(TABLE_ENTRIES);
  localparam int PROD_W = (IW + STEP_W > START_W - 1) ? IW + STEP_W : START_W - 1;
  localparam int BASE_W = PROD_W + 2;
  localparam int RES_W  = ((BASE_W > NUM_W + 1) ? BASE_W : NUM_W + 1) + 1;
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);
  localparam logic signed [RES_W-1:0] SatMax = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SatMin = RES_W'(-32768);

  // Calibration ROM
  logic [ADC_W-1:0] rom_mem [TABLE_ENTRIES];
  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
    if (gi < CURVE_LEN) begin : g_curve
      assign rom_mem[gi] = CURVE[gi];
    end else begin : g_zero
      assign rom_mem[gi] = '0;
    end
  end

  // Configuration registers
  logic [START_W-1:0] start_q;
  logic [STEP_W-1:0]  step_q;
  logic [TEMP_W-1:0]  under_q, over_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_W'(-50);
      step_q  <= STEP_W'(10);
      under_q <= TEMP_W'(-50);
      over_q  <= TEMP_W'(1000);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START: start_q <= pwdata[START_W-1:0];
        REG_STEP:  step_q  <= pwdata[STEP_W-1:0];
        REG_UNDER: under_q <= pwdata[TEMP_W-1:0];
        REG_OVER:  over_q  <= pwdata[TEMP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START: prdata = {{(32-START_W){1'b0}}, start_q};
      REG_STEP:  prdata = {{(32-STEP_W){1'b0}}, step_q};
      REG_UNDER: prdata = {{(32-TEMP_W){1'b0}}, under_q};
      REG_OVER:  prdata = {{(32-TEMP_W){1'b0}}, over_q};
    endcase
  end

  // Work registers
  state_e                   state_q, state_d;
  logic [ADC_W-1:0]         adc_q, adc_d;
  logic [IW-1:0]            lo_q, lo_d, hi_q, hi_d, addr_q, addr_d, tidx_q, tidx_d;
  logic [ADC_W-1:0]         rom_q, vl_q, vl_d;
  logic                     sub_q, sub_d;
  range_e                   status_q, status_d;
  logic signed [BASE_W-1:0] base_q, base_d;
  logic [NUM_W-1:0]         quo_q, quo_d;
  logic [ADC_W-1:0]         rem_q, rem_d, div_q, div_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     m_valid_q, m_valid_d;
  logic [TEMP_W-1:0]        m_temp_q, m_temp_d;
  range_e                   m_status_q, m_status_d;

  // Shared compare and search logic
  logic             in_xfer, out_free, adc_lt, adc_gt, adc_eq, gap_wide, interp;
  logic [IW-1:0]    srch_lo, srch_hi, srch_rd;
  logic [IW:0]      mid_sum;
  logic [ADC_W-1:0] span, diff;
  logic [ADC_W:0]   rem_sh;
  logic             div_ge;
  logic signed [RES_W-1:0] res;
  logic [TEMP_W-1:0] res_sat;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign adc_lt          = adc_q < rom_q;
  assign adc_gt          = adc_q > rom_q;
  assign adc_eq          = adc_q == rom_q;

  always_comb begin
    if (state_q == ST_FIRST) begin
      srch_lo = '0;
      srch_hi = LastIdx;
    end else if (adc_gt) begin
      srch_lo = lo_q;
      srch_hi = addr_q;
    end else begin
      srch_lo = addr_q;
      srch_hi = hi_q;
    end
    gap_wide = (srch_hi - srch_lo) > IW'(1);
    mid_sum  = {1'b0, srch_lo} + {1'b0, srch_hi};
    srch_rd  = gap_wide ? mid_sum[IW:1] : srch_lo;
  end

  assign span   = vl_q - rom_q;
  assign diff   = adc_q - rom_q;
  assign interp = (vl_q > rom_q) && !adc_lt;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign div_ge = rem_sh >= {1'b0, div_q};

  always_comb begin
    res = RES_W'(base_q);
    if (sub_q) begin
      res = RES_W'(base_q) - RES_W'(quo_q);
    end
    if (res > SatMax) begin
      res_sat = TEMP_W'(SatMax);
    end else if (res < SatMin) begin
      res_sat = TEMP_W'(SatMin);
    end else begin
      res_sat = res[TEMP_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_LAST;
      ST_LAST: begin
        if (adc_lt) begin
          state_d = ST_DONE;
        end else if (adc_eq) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (adc_gt) begin
          state_d = ST_DONE;
        end else if (adc_eq) begin
          state_d = ST_MUL;
        end else begin
          state_d = gap_wide ? ST_SEARCH : ST_LOW;
        end
      end
      ST_SEARCH: state_d = gap_wide ? ST_SEARCH : ST_LOW;
      ST_LOW:    state_d = adc_lt ? ST_HIGH : ST_MUL;
      ST_HIGH:   state_d = ST_MUL;
      ST_MUL:    state_d = sub_q ? ST_DIV : ST_DONE;
      ST_DIV:    if (cnt_q == CNT_W'(NUM_W - 1)) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    adc_d      = adc_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    addr_d     = addr_q;
    tidx_d     = tidx_q;
    vl_d       = vl_q;
    sub_d      = sub_q;
    status_d   = status_q;
    base_d     = base_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    div_d      = div_q;
    cnt_d      = cnt_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_temp_d   = m_temp_q;
    m_status_d = m_status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          adc_d    = s_axis_tdata_i;
          addr_d   = LastIdx;
          status_d = RANGE_IN;
          sub_d    = 1'b0;
        end
      end
      ST_LAST: begin
        if (adc_lt) begin
          status_d = RANGE_OVER;
        end else if (adc_eq) begin
          tidx_d = LastIdx;
        end else begin
          addr_d = '0;
        end
      end
      ST_FIRST: begin
        if (adc_gt) begin
          status_d = RANGE_UNDER;
        end else if (adc_eq) begin
          tidx_d = '0;
        end else begin
          lo_d   = srch_lo;
          hi_d   = srch_hi;
          addr_d = srch_rd;
        end
      end
      ST_SEARCH: begin
        lo_d   = srch_lo;
        hi_d   = srch_hi;
        addr_d = srch_rd;
      end
      ST_LOW: begin
        // Reading at or above the lower bound entry lands on it exactly.
        tidx_d = lo_q;
        vl_d   = rom_q;
        addr_d = hi_q;
      end
      ST_HIGH: begin
        tidx_d = hi_q;
        sub_d  = interp;
        quo_d  = NUM_W'(step_q) * NUM_W'(diff) + NUM_W'(span[ADC_W-1:1]);
        div_d  = span;
        rem_d  = '0;
        cnt_d  = '0;
      end
      ST_MUL: begin
        base_d = BASE_W'($signed(start_q)) + $signed(BASE_W'(step_q) * BASE_W'(tidx_q));
      end
      ST_DIV: begin
        rem_d = div_ge ? ADC_W'(rem_sh - {1'b0, div_q}) : rem_sh[ADC_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          case (status_q)
            RANGE_UNDER: m_temp_d = under_q;
            RANGE_OVER:  m_temp_d = over_q;
            default:     m_temp_d = res_sat;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q      <= rom_mem[addr_d];
    adc_q      <= adc_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    addr_q     <= addr_d;
    tidx_q     <= tidx_d;
    vl_q       <= vl_d;
    sub_q      <= sub_d;
    status_q   <= status_d;
    base_q     <= base_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    cnt_q      <= cnt_d;
    m_temp_q   <= m_temp_d;
    m_status_q <= m_status_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_temp_q;
  assign m_axis_tuser_o  = m_status_q;

  `ASSERT_NEXT(a_accept_reads_last, clk_i, rst_ni, in_xfer, state_q == ST_LAST,
               "accepted reading did not start with the last table entry")
  `ASSERT_IMPLY(a_search_gap, clk_i, rst_ni, state_q == ST_SEARCH, (hi_q - lo_q) > IW'(1),
                "binary search running with adjacent bounds")
  `ASSERT_IMPLY(a_div_nonzero, clk_i, rst_ni, state_q == ST_DIV, div_q != '0,
                "divider running with a zero span")
  `ASSERT_IMPLY(a_status_legal, clk_i, rst_ni, m_axis_tvalid_o,
                m_axis_tuser_o == RANGE_IN || m_axis_tuser_o == RANGE_UNDER ||
                m_axis_tuser_o == RANGE_OVER,
                "range status code out of range")

endmodule
